// File: hw/rtl/dma_channel_test_device_assert.svh
// assertion macros for the channel exerciser
// included by the top level, depends on nothing
`ifndef DMA_CHANNEL_TEST_DEVICE_ASSERT_SVH
`define DMA_CHANNEL_TEST_DEVICE_ASSERT_SVH
// implication checked every clock outside reset
`define DCT_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define DCT_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/dct_pkg.sv
// shared types and constants of the channel exerciser
// no dependencies
package dct_pkg;
    localparam int unsigned MaxChannels = 16;
    localparam int unsigned ChanW = 4;
    localparam logic [15:0] TapsReset = 16'hB400;

    typedef enum logic [2:0] {
        K_INPUT = 3'd0, K_OUTPUT = 3'd1, K_SKIP = 3'd2, K_PULSE = 3'd3,
        K_MASK = 3'd4, K_TICK = 3'd5, K_XFER = 3'd6, K_CLEAR = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE, S_EXEC, S_CLEAR
    } t_state;

    // one channel entry of the state memory
    typedef struct packed {
        logic [15:0] size_word;
        logic [15:0] data_gen;
        logic [15:0] time_gen;
        logic [15:0] time_control;
        logic [15:0] running_sum;
        logic [15:0] remaining;
        logic [15:0] pending;
        logic        last_flag;
        logic [2:0]  err_bits;
    } t_entry;

    localparam int unsigned EntryW = $bits(t_entry);

    typedef struct packed {
        logic [2:0]  kind;
        logic        central;
        logic [2:0]  func;
        logic [15:0] data;
        logic [3:0]  event_chan;
        logic        end_of_record;
    } t_in;

    typedef struct packed {
        logic        ready_res;
        logic [15:0] read_data;
        logic [15:0] xfer_data;
        logic        xfer_data_valid;
        logic        irq;
        logic        dma_request;
        logic        timer_start;
        logic [15:0] timer_delay;
        logic [3:0]  out_chan;
    } t_out;

    localparam int unsigned InW = $bits(t_in);
    localparam int unsigned OutW = $bits(t_out);

    function automatic logic [15:0] galois(input logic [15:0] v, input logic [15:0] taps);
        galois = (v >> 1) ^ (v[0] ? taps : 16'h0000);
    endfunction

    function automatic logic [15:0] rot_right(input logic [15:0] v);
        rot_right = {v[0], v[15:1]};
    endfunction
endpackage

// File: hw/rtl/dct_if.sv
// valid/ready channel interface carrying a packed payload
// depends on nothing
interface dct_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/dct_cfg_if.sv
// configuration write interface
// depends on nothing
interface dct_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/dct_ram.sv
// generic single-port-write ram with registered read
// depends on nothing
module dct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/dma_channel_test_device.sv
// channel exerciser: each item reads its channel entry, then modifies it and writes it
// back; a result register holds the answer; next item accepted
// once the result is taken or with it. a clear item or reset runs a clearing pass
// over every entry of the entry memory, items wait meanwhile, configuration
// writes are always taken outside reset. result valid is registered from the execute state.
module dma_channel_test_device
    import dct_pkg::*;
#(
    parameter int unsigned CHANNELS = MaxChannels
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dct_if.sink     in_ch,
    dct_if.source   out_ch,
    dct_cfg_if.sink cfg_ch
);
    localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [AW:0] LastAddr = (AW + 1)'(CHANNELS - 1);

    // configuration registers
    logic [15:0] r_taps;
    logic [3:0]  r_maskpos;

    // central state
    t_state      r_state, n_state;
    logic        r_irq_enable, n_irq_enable;
    logic [3:0]  r_sel, n_sel;
    logic [15:0] r_busy, n_busy, r_irqf, n_irqf, r_stray, n_stray, r_inmode, n_inmode;
    t_in         r_item;
    logic [AW:0] r_clr_addr;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;

    // entry memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, ram_rdata;

    logic [15:0] present;
    logic [3:0]  chan;
    logic        chan_ok;
    t_entry      e, ne;
    logic        accept;

    assign present = (CHANNELS >= 16) ? 16'hffff : 16'(({17'b0, 1'b1} << CHANNELS) - 17'd1);

    // item address: event channel for ticks and transfers, selected otherwise
    t_in in_w;
    assign in_w = t_in'(in_ch.payload);
    logic use_ev;
    assign use_ev = (t_kind'(r_item.kind) == K_TICK) || (t_kind'(r_item.kind) == K_XFER);
    assign chan    = use_ev ? r_item.event_chan : r_sel;
    assign chan_ok = ({1'b0, chan} < 5'(CHANNELS));

    assign in_ch.ready  = (r_state == S_IDLE) && (!r_out_valid || out_ch.ready);
    assign accept       = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_out_valid;
    assign out_ch.payload = r_out;

    dct_ram #(.WIDTH(EntryW), .DEPTH(CHANNELS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // read address chosen at acceptance
    always_comb begin
        logic [3:0] a;
        a = ((t_kind'(in_w.kind) == K_TICK) || (t_kind'(in_w.kind) == K_XFER))
            ? in_w.event_chan : r_sel;
        ram_raddr = AW'(a);
    end
    assign e = ram_rdata;

    // first set bit of a present-masked flag word
    function automatic logic [15:0] first_set(input logic [15:0] f);
        first_set = 16'hffff;
        for (int i = 15; i >= 0; i--) begin
            if (f[i]) begin
                first_set = 16'(i);
            end
        end
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC:  if (t_kind'(r_item.kind) == K_CLEAR) n_state = S_CLEAR;
                     else n_state = S_IDLE;
            S_CLEAR: if (r_clr_addr == LastAddr) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // execute: modify the entry that was read and form the result
    always_comb begin
        logic [15:0] bit_m, tc, mask, word;
        logic        last, sched, has_err, irq_lvl;
        logic [3:0]  sc;
        n_irq_enable = r_irq_enable;
        n_sel = r_sel; n_busy = r_busy; n_irqf = r_irqf;
        n_stray = r_stray; n_inmode = r_inmode;
        n_out = '0;
        n_out.ready_res = 1'b1;
        ne = e;
        ram_we = 1'b0;
        ram_waddr = AW'(chan);
        ram_wdata = e;
        bit_m = 16'(17'd1 << chan);
        sched = 1'b0;
        last = 1'b0;
        word = r_item.data;
        has_err = 1'b0;
        irq_lvl = 1'b0;
        sc = chan;
        tc = 16'h0;
        mask = 16'h0;
        n_out_valid = r_out_valid && !out_ch.ready;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
            ram_waddr = r_clr_addr[AW-1:0];
            ram_wdata = '0;
        end else if (r_state == S_EXEC) begin
            n_out_valid = 1'b1;
            case (t_kind'(r_item.kind))
                K_INPUT: begin
                    if (r_item.central) begin
                        case (r_item.func)
                            3'd0: n_out.read_data = {12'h0, r_sel};
                            3'd1: n_out.read_data = first_set(r_irqf & present);
                            3'd2: n_out.read_data = first_set(r_stray & present);
                            default: n_out.ready_res = 1'b0;
                        endcase
                    end else if (chan_ok) begin
                        case (r_item.func)
                            3'd0: n_out.read_data = e.size_word;
                            3'd1: n_out.read_data = e.data_gen;
                            3'd2: n_out.read_data = e.time_gen;
                            3'd3: n_out.read_data = e.time_control;
                            3'd4: n_out.read_data = {11'h0, (e.running_sum != 0),
                                                     e.err_bits, r_stray[chan]};
                            default: n_out.ready_res = 1'b0;
                        endcase
                    end else if (r_item.func > 3'd4) begin
                        n_out.ready_res = 1'b0;
                    end
                end
                K_OUTPUT: begin
                    if (r_item.central) begin
                        if (r_item.func == 3'd0) n_sel = r_item.data[3:0];
                        else n_out.ready_res = 1'b0;
                    end else if (r_item.func <= 3'd3) begin
                        if (chan_ok) begin
                            case (r_item.func)
                                3'd0: ne.size_word = r_item.data;
                                3'd1: ne.data_gen = r_item.data;
                                3'd2: ne.time_gen = r_item.data;
                                default: ne.time_control = r_item.data;
                            endcase
                            ram_we = 1'b1;
                        end
                    end else begin
                        n_out.ready_res = 1'b0;
                    end
                end
                K_SKIP: begin
                    has_err = r_stray[chan] || (chan_ok && (e.err_bits != 0
                              || e.running_sum != 0));
                    if (r_item.central) begin
                        case (r_item.func)
                            3'd0: n_out.ready_res = (r_busy & present) == 0;
                            3'd1: n_out.ready_res = !(r_irq_enable && (r_irqf & present) != 0);
                            3'd2: n_out.ready_res = (r_stray & present) == 0;
                            default: n_out.ready_res = 1'b0;
                        endcase
                    end else begin
                        case (r_item.func)
                            3'd0: n_out.ready_res = !r_busy[chan];
                            3'd1: n_out.ready_res = has_err;
                            3'd2: n_out.ready_res = r_irqf[chan];
                            default: n_out.ready_res = 1'b0;
                        endcase
                    end
                end
                K_PULSE: begin
                    if (r_item.central) begin
                        if (r_item.func == 3'd0) n_stray = '0;
                    end else if (chan_ok) begin
                        case (r_item.func)
                            3'd0, 3'd1: begin
                                if (r_item.func == 3'd1) n_inmode = r_inmode | bit_m;
                                else n_inmode = r_inmode & ~bit_m;
                                ne.remaining = e.size_word - 16'd1;
                                ne.pending = '0;
                                ne.last_flag = 1'b0;
                                ne.running_sum = '0;
                                ne.err_bits = '0;
                                n_irqf = r_irqf & ~bit_m;
                                n_busy = r_busy | bit_m;
                                sched = 1'b1;
                                ram_we = 1'b1;
                            end
                            3'd2: n_irqf = r_irqf & ~bit_m;
                            3'd3: begin
                                ne.err_bits = '0;
                                ram_we = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                K_MASK: n_irq_enable = r_item.data[r_maskpos];
                K_TICK: begin
                    n_out.ready_res = 1'b0;
                    if (chan_ok) begin
                        ram_we = 1'b1;
                        if (e.pending != 16'hffff) ne.pending = e.pending + 16'd1;
                        n_out.dma_request = 1'b1;
                        n_out.out_chan = chan;
                        if (e.remaining == 0) ne.last_flag = 1'b1;
                        else begin
                            ne.remaining = e.remaining - 16'd1;
                            sched = 1'b1;
                        end
                    end
                end
                K_XFER: begin
                    n_out.ready_res = 1'b0;
                    if (chan_ok) begin
                        if (e.pending == 0) begin
                            n_stray = r_stray | bit_m;
                        end else begin
                            ram_we = 1'b1;
                            last = (e.pending == 16'd1) && e.last_flag;
                            ne.pending = e.pending - 16'd1;
                            if (r_item.end_of_record && !last) ne.err_bits[0] = 1'b1;
                            else if (last && !r_item.end_of_record) ne.err_bits[1] = 1'b1;
                            if (r_inmode[chan]) begin
                                word = last ? (16'h0 - rot_right(e.running_sum)) : e.data_gen;
                                n_out.xfer_data = word;
                                n_out.xfer_data_valid = 1'b1;
                            end else if (!last && word != e.data_gen) begin
                                ne.err_bits[2] = 1'b1;
                            end
                            ne.running_sum = rot_right(e.running_sum) + word;
                            if (last) begin
                                n_busy = r_busy & ~bit_m;
                                n_irqf = r_irqf | bit_m;
                            end else begin
                                ne.data_gen = galois(e.data_gen, r_taps);
                            end
                        end
                    end
                end
                default: begin
                    // clear: central state here, entries by the clearing pass
                    n_out.ready_res = 1'b0;
                    n_irq_enable = 1'b0;
                    n_sel = '0; n_busy = '0; n_irqf = '0; n_stray = '0; n_inmode = '0;
                end
            endcase
            if (sched) begin
                tc = e.time_control;
                mask = 16'((17'd1 << tc[15:12]) - 17'd1);
                n_out.timer_start = 1'b1;
                n_out.timer_delay = {4'h0, tc[11:0]} + (e.time_gen & mask);
                n_out.out_chan = sc;
                if (mask != 0) ne.time_gen = galois(e.time_gen, r_taps);
            end
            if (ram_we) ram_wdata = ne;
            irq_lvl = n_irq_enable && ((n_irqf & present) != 0);
            n_out.irq = irq_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr_addr <= '0;
            r_taps <= TapsReset;
            r_maskpos <= '0;
            r_irq_enable <= 1'b0;
            r_sel <= '0;
            r_busy <= '0; r_irqf <= '0; r_stray <= '0; r_inmode <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_irq_enable <= n_irq_enable;
            r_sel <= n_sel;
            r_busy <= n_busy; r_irqf <= n_irqf; r_stray <= n_stray; r_inmode <= n_inmode;
            r_out_valid <= n_out_valid;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            else r_clr_addr <= '0;
            if (cfg_ch.valid) begin
                if (cfg_ch.index == 1'b0) r_taps <= cfg_ch.data;
                else r_maskpos <= cfg_ch.data[3:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) r_item <= in_w;
        if (r_state == S_EXEC) r_out <= n_out;
    end

    `include "dma_channel_test_device_assert.svh"
    `DCT_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !in_ch.ready)
    `DCT_ASSERT_NXT(a_exec_result, i_clk, i_rst_n, r_state == S_EXEC, r_out_valid)
    `DCT_ASSERT_IMP(a_clear_writes, i_clk, i_rst_n, r_state == S_CLEAR, ram_we)
endmodule
